// File: sv/u8u32_pkg.sv
// Package: result kinds, result record and constants for the UTF-8 to UTF-32 decoder.
`default_nettype none

package u8u32_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned WORD_W   = 21;
    localparam int unsigned TDATA_W  = 24;
    localparam int unsigned QDEPTH_W = 2;

    localparam logic [WORD_W-1:0] BOM_WORD = 21'h00feff;

    typedef enum logic [1:0] {
        KIND_BOM  = 2'd0,
        KIND_CHAR = 2'd1,
        KIND_ERR  = 2'd2
    } kind_t;

    typedef struct packed {
        logic [WORD_W-1:0] word;
        kind_t             kind;
        logic              last;
    } result_t;

endpackage

`default_nettype wire

// File: sv/utf8_to_utf32_decoder.sv
// Top level: UTF-8 byte stream in, UTF-32 code point items out.
//
//  channel   | direction | tdata                         | tuser          | tlast
//  ----------+-----------+-------------------------------+----------------+------
//  s_axis_*  | in        | [7:0] data_byte               | start_stream   | -
//  m_axis_*  | out       | [20:0] out_word, [23:21] zero | [1:0] kind     | last
//
// One byte is accepted every cycle while each byte yields at most one result and no
// stall on m_axis_tready holds the result queue; a byte flagged as a stream start that
// also completes a character yields two results and is held until the queue has room for both.
// A byte passes through the input register, then the two-entry result queue, before
// its first result is valid.
// Reset (aresetn low, synchronous) empties both stages and returns the decoder to idle.
// A stall on m_axis_tready backs up through the result queue into the input register.
`default_nettype none

module utf8_to_utf32_decoder
    import u8u32_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,

    input  wire logic               s_axis_tvalid,
    output logic                    s_axis_tready,
    input  wire logic [BYTE_W-1:0]  s_axis_tdata,   // [7:0] data_byte
    input  wire logic               s_axis_tuser,   // [0] start_stream

    output logic                    m_axis_tvalid,
    input  wire logic               m_axis_tready,
    output logic [TDATA_W-1:0]      m_axis_tdata,   // [20:0] out_word, [23:21] zero
    output logic [1:0]              m_axis_tuser,   // [1:0] kind
    output logic                    m_axis_tlast    // last result of its byte
);

    // input register
    logic              in_valid_reg;
    logic [BYTE_W-1:0] in_byte_reg;
    logic              in_start_reg;

    // decoder state
    logic [1:0]        bytes_left_reg, bytes_left_next;
    logic [WORD_W-1:0] accum_reg, accum_next;

    // result queue, entry 0 is the head
    result_t             q_reg [2];
    result_t             q_next [2];
    logic [QDEPTH_W-1:0] count_reg, count_next;

    // decode
    logic [1:0]        eff_left;
    logic [WORD_W-1:0] eff_accum;
    logic [WORD_W-1:0] cont_accum;
    logic [1:0]        left_dec;
    logic              char_valid;
    result_t           char_res;
    result_t           bom_res;
    result_t           res0, res1;
    logic [1:0]        n_res;

    // queue control
    logic                pop;
    logic                adv;
    logic [QDEPTH_W-1:0] base;
    logic [2:0]          fill_sum;
    result_t             sh0, sh1;

    // ---------------------------------------------------------------------
    // Decode the held byte against the current state
    // ---------------------------------------------------------------------
    always_comb begin
        // start flag drops any unfinished sequence
        eff_left   = in_start_reg ? 2'd0 : bytes_left_reg;
        eff_accum  = in_start_reg ? '0 : accum_reg;
        cont_accum = {eff_accum[WORD_W-7:0], in_byte_reg[5:0]};
        left_dec   = eff_left - 2'd1;

        char_valid      = 1'b0;
        char_res.word   = '0;
        char_res.kind   = KIND_CHAR;
        char_res.last   = 1'b1;
        bytes_left_next = eff_left;
        accum_next      = eff_accum;

        if (eff_left != 2'd0) begin
            // any byte inside a sequence counts as a continuation
            bytes_left_next = left_dec;
            if (left_dec == 2'd0) begin
                char_valid    = 1'b1;
                char_res.word = cont_accum;
                accum_next    = '0;
            end else begin
                accum_next = cont_accum;
            end
        end else begin
            case (in_byte_reg) inside
                8'b0???_????: begin
                    char_valid    = 1'b1;
                    char_res.word = {{(WORD_W-BYTE_W){1'b0}}, in_byte_reg};
                    accum_next    = '0;
                end
                8'b110?_????: begin
                    accum_next      = {{(WORD_W-5){1'b0}}, in_byte_reg[4:0]};
                    bytes_left_next = 2'd1;
                end
                8'b1110_????: begin
                    accum_next      = {{(WORD_W-4){1'b0}}, in_byte_reg[3:0]};
                    bytes_left_next = 2'd2;
                end
                8'b1111_0???: begin
                    accum_next      = {{(WORD_W-3){1'b0}}, in_byte_reg[2:0]};
                    bytes_left_next = 2'd3;
                end
                default: begin
                    // lone continuation or five and more leading ones
                    char_valid    = 1'b1;
                    char_res.kind = KIND_ERR;
                    accum_next    = '0;
                end
            endcase
        end

        bom_res.word = BOM_WORD;
        bom_res.kind = KIND_BOM;
        bom_res.last = !char_valid;

        // order the results: mark first when flagged
        if (in_start_reg) begin
            res0  = bom_res;
            res1  = char_res;
            n_res = char_valid ? 2'd2 : 2'd1;
        end else begin
            res0  = char_res;
            res1  = char_res;
            n_res = {1'b0, char_valid};
        end
    end

    // ---------------------------------------------------------------------
    // Result queue: pop at the head, append up to two results at the tail
    // ---------------------------------------------------------------------
    assign pop      = m_axis_tvalid && m_axis_tready;
    assign base     = count_reg - {{(QDEPTH_W-1){1'b0}}, pop};
    assign fill_sum = {1'b0, base} + {1'b0, n_res};
    assign adv      = in_valid_reg && (fill_sum <= 3'd2);

    assign s_axis_tready = !in_valid_reg || adv;

    always_comb begin
        sh0 = pop ? q_reg[1] : q_reg[0];
        sh1 = q_reg[1];
        q_next[0] = sh0;
        q_next[1] = sh1;
        count_next = base;
        if (adv) begin
            count_next = fill_sum[QDEPTH_W-1:0];
            if (base == 2'd0) begin
                q_next[0] = res0;
                q_next[1] = res1;
            end else if (base == 2'd1) begin
                q_next[1] = res0;
            end
        end
    end

    // ---------------------------------------------------------------------
    // Registers
    // ---------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg   <= 1'b0;
            bytes_left_reg <= 2'd0;
            accum_reg      <= '0;
            count_reg      <= '0;
        end else begin
            if (s_axis_tready) begin
                in_valid_reg <= s_axis_tvalid;
            end
            if (adv) begin
                bytes_left_reg <= bytes_left_next;
                accum_reg      <= accum_next;
            end
            count_reg <= count_next;
        end
    end

    // payload: no reset
    always_ff @(posedge aclk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            in_byte_reg  <= s_axis_tdata;
            in_start_reg <= s_axis_tuser;
        end
        q_reg[0] <= q_next[0];
        q_reg[1] <= q_next[1];
    end

    // ---------------------------------------------------------------------
    // Outputs
    // ---------------------------------------------------------------------
    assign m_axis_tvalid = (count_reg != '0);
    assign m_axis_tdata  = {{(TDATA_W-WORD_W){1'b0}}, q_reg[0].word};
    assign m_axis_tuser  = q_reg[0].kind;
    assign m_axis_tlast  = q_reg[0].last;

    // ---------------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------------
    a_queue_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg != 2'd3)
        else $error("result queue count out of range");

    a_idle_accum_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        bytes_left_reg == 2'd0 |-> accum_reg == '0)
        else $error("accumulator not cleared while idle");

    a_bom_pair: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && q_reg[0].kind == KIND_BOM && !q_reg[0].last)
            |-> count_reg == 2'd2)
        else $error("mark without its following result");

    a_err_word: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && q_reg[0].kind == KIND_ERR) |-> q_reg[0].word == '0)
        else $error("error item with nonzero word");

    a_no_advance_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && count_reg == 2'd2 && !m_axis_tready && n_res != 2'd0)
            |=> $stable(in_byte_reg))
        else $error("input advanced into a full queue");

endmodule

`default_nettype wire

// File: dv/utf32_result_checker.sv
// Checker: predicts UTF-32 result words from accepted UTF-8 bytes and compares them.
module utf32_result_checker
    import u8u32_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_axis_tvalid,
    input  wire logic               s_axis_tready,
    input  wire logic [BYTE_W-1:0]  s_axis_tdata,
    input  wire logic               s_axis_tuser,
    input  wire logic               m_axis_tvalid,
    input  wire logic               m_axis_tready,
    input  wire logic [TDATA_W-1:0] m_axis_tdata,
    input  wire logic [1:0]         m_axis_tuser,
    input  wire logic               m_axis_tlast,
    output int                      fail_count,
    output int                      words_pending,
    output int                      words_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    result_t           expected_words[$];
    logic [1:0]        cont_left;
    logic [WORD_W-1:0] partial_cp;
    int                errs;
    int                checked;

    // Work out the words one byte causes and queue them in order.
    task automatic decode_utf8_byte(input logic [BYTE_W-1:0] b, input logic sos);
        result_t     words[$];
        result_t     w;
        int unsigned ones;
        if (sos) begin
            w = '{word: BOM_WORD, kind: KIND_BOM, last: 1'b0};
            words.push_back(w);
            cont_left  = '0;
            partial_cp = '0;
        end
        if (cont_left != 0) begin
            partial_cp = {partial_cp[WORD_W-7:0], b[5:0]};
            cont_left  = cont_left - 2'd1;
            if (cont_left == 0) begin
                w = '{word: partial_cp, kind: KIND_CHAR, last: 1'b0};
                words.push_back(w);
                partial_cp = '0;
            end
        end else begin
            ones = 0;
            while (ones < 8 && b[7 - ones])
                ones++;
            if (ones == 0) begin
                w = '{word: WORD_W'(b), kind: KIND_CHAR, last: 1'b0};
                words.push_back(w);
                partial_cp = '0;
            end else if (ones == 1 || ones >= 5) begin
                w = '{word: '0, kind: KIND_ERR, last: 1'b0};
                words.push_back(w);
                partial_cp = '0;
            end else begin
                partial_cp = WORD_W'(b & (8'h7f >> ones));
                cont_left  = 2'(ones - 1);
            end
        end
        if (words.size() > 0)
            words[words.size() - 1].last = 1'b1;
        foreach (words[i])
            expected_words.push_back(words[i]);
    endtask

    always @(posedge aclk) begin
        result_t want;
        if (!aresetn) begin
            expected_words.delete();
            cont_left  = '0;
            partial_cp = '0;
        end else begin
            // compare before queueing: a byte never yields a word at its own edge
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_words.size() == 0) begin
                    $error("unexpected word: out_word %06h kind %0d last %b",
                           m_axis_tdata[WORD_W-1:0], m_axis_tuser, m_axis_tlast);
                    errs++;
                end else begin
                    want = expected_words.pop_front();
                    checked++;
                    if (m_axis_tdata[WORD_W-1:0] !== want.word) begin
                        $error("out_word: expected %06h, got %06h",
                               want.word, m_axis_tdata[WORD_W-1:0]);
                        errs++;
                    end
                    if (m_axis_tdata[TDATA_W-1:WORD_W] !== '0) begin
                        $error("tdata padding: expected 0, got %0h",
                               m_axis_tdata[TDATA_W-1:WORD_W]);
                        errs++;
                    end
                    if (m_axis_tuser !== want.kind) begin
                        $error("kind: expected %0d, got %0d", want.kind, m_axis_tuser);
                        errs++;
                    end
                    if (m_axis_tlast !== want.last) begin
                        $error("last: expected %b, got %b", want.last, m_axis_tlast);
                        errs++;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                decode_utf8_byte(s_axis_tdata, s_axis_tuser);
        end
        fail_count    <= errs;
        words_pending <= expected_words.size();
        words_checked <= checked;
    end

endmodule

// File: dv/testbench.sv
// Testbench top: drives UTF-8 bytes into the decoder, stalls the result side, gives the verdict.
module testbench
    import u8u32_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CYCLE_LIMIT = 200000;
    // receiver hold-off: start tick and length, long enough to back the block up
    localparam int unsigned HOLD_AT     = 500;
    localparam int unsigned HOLD_SPAN   = 300;
    localparam int unsigned SETTLE      = 10;

    // bit 8 = start of stream, bits 7:0 = byte
    localparam logic [8:0] DIRECTED_BYTES [25] = '{
        9'h100,                         // NUL opening a stream: mark plus character
        9'h07f,                         // largest single byte
        9'h080,                         // lone continuation
        9'h0df, 9'h0bf,                 // largest two-byte form
        9'h0ef, 9'h0bf, 9'h0bf,         // largest three-byte form
        9'h0f7, 9'h0bf, 9'h0bf, 9'h0bf, // largest four-byte form, all 21 bits set
        9'h0f8, 9'h0ff,                 // five and eight leading ones
        9'h0c3, 9'h041,                 // continuation slot filled by a plain byte
        9'h0e2, 9'h082, 9'h141,         // stream start cuts a sequence short
        9'h1f0, 9'h09f, 9'h098, 9'h080, // four-byte lead with start: mark alone
        9'h180,                         // start on a lone continuation
        9'h1ff                          // start on an invalid lead
    };

    typedef struct packed {
        logic                  sos;
        logic [BYTE_W-1:0]     b;
    } utf8_item_t;

    logic               aclk          = 1'b0;
    logic               aresetn       = 1'b0;
    logic               s_axis_tvalid = 1'b0;
    logic               s_axis_tready;
    logic [BYTE_W-1:0]  s_axis_tdata  = '0;
    logic               s_axis_tuser  = 1'b0;
    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b0;
    logic [TDATA_W-1:0] m_axis_tdata;
    logic [1:0]         m_axis_tuser;
    logic               m_axis_tlast;

    int                 fail_count;
    int                 words_pending;
    int                 words_checked;
    int unsigned        bytes_sent    = 0;
    int unsigned        cycle_count;

    utf8_item_t         byte_plan[$];

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    utf8_to_utf32_decoder i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    utf32_result_checker i_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .fail_count    (fail_count),
        .words_pending (words_pending),
        .words_checked (words_checked)
    );

    task automatic plan_byte(input logic [BYTE_W-1:0] b, input logic sos);
        byte_plan.push_back('{sos: sos, b: b});
    endtask

    // Fill the plan up to n_bytes: mostly well-formed sequences with random
    // payload, the rest truncated sequences, lone continuations, bad leads and noise.
    task automatic plan_random_text(input int unsigned n_bytes);
        int unsigned       pick;
        int unsigned       len;
        int unsigned       cut;
        logic [BYTE_W-1:0] lead;
        logic [BYTE_W-1:0] cont;
        while (byte_plan.size() < n_bytes) begin
            pick = $urandom_range(0, 99);
            lead = 8'($urandom());
            if (pick < 80) begin
                len = $urandom_range(1, 4);
                case (len)
                    1: lead[7]   = 1'b0;
                    2: lead[7:5] = 3'b110;
                    3: lead[7:4] = 4'b1110;
                    default: lead[7:3] = 5'b11110;
                endcase
                plan_byte(lead, $urandom_range(0, 29) == 0);
                for (int k = 1; k < len; k++) begin
                    cont = {2'b10, 6'($urandom())};
                    // now and then a foreign prefix, which the block must ignore
                    if ($urandom_range(0, 9) == 0)
                        cont[7:6] = 2'($urandom());
                    // rarely restart the stream in mid-sequence
                    plan_byte(cont, $urandom_range(0, 49) == 0);
                end
            end else if (pick < 88) begin
                // lead then too few continuations: the next bytes finish it
                len = $urandom_range(2, 4);
                lead[7:0] = (len == 2) ? {3'b110, lead[4:0]} :
                            (len == 3) ? {4'b1110, lead[3:0]} : {5'b11110, lead[2:0]};
                plan_byte(lead, 1'b0);
                cut = $urandom_range(0, len - 2);
                for (int k = 0; k < cut; k++)
                    plan_byte({2'b10, 6'($urandom())}, 1'b0);
            end else if (pick < 93) begin
                plan_byte({2'b10, lead[5:0]}, $urandom_range(0, 7) == 0);
            end else if (pick < 97) begin
                plan_byte({5'b11111, lead[2:0]}, $urandom_range(0, 7) == 0);
            end else begin
                plan_byte(lead, 1'($urandom()));
            end
        end
    endtask

    // Offer the planned bytes in bursts of random length with random gaps.
    task automatic send_plan();
        utf8_item_t  cur;
        int unsigned burst;
        int unsigned gap;
        burst = 0;
        while (byte_plan.size() != 0) begin
            if (burst == 0) begin
                burst = $urandom_range(1, 32);
                gap   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                if (gap != 0) begin
                    s_axis_tvalid <= 1'b0;
                    repeat (gap) @(posedge aclk);
                end
            end
            cur = byte_plan.pop_front();
            s_axis_tvalid <= 1'b1;
            s_axis_tdata  <= cur.b;
            s_axis_tuser  <= cur.sos;
            @(posedge aclk);
            while (!s_axis_tready) @(posedge aclk);
            bytes_sent++;
            burst--;
        end
        s_axis_tvalid <= 1'b0;
    endtask

    // Hold the sender until every queued word has come out.
    task automatic wait_for_drain();
        do @(posedge aclk); while (words_pending != 0);
    endtask

    // Receiver: segments of random stall patterns, one long hold-off early on.
    initial begin
        int unsigned mode;
        int unsigned span;
        int unsigned ticks;
        bit          held;
        ticks = 0;
        held  = 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(4, 64);
            if (!held && ticks >= HOLD_AT) begin
                held = 1'b1;
                mode = 4;
                span = HOLD_SPAN;
            end
            repeat (span) begin
                @(posedge aclk);
                ticks++;
                case (mode)
                    0: m_axis_tready <= 1'b1;
                    1: m_axis_tready <= 1'($urandom());
                    2: m_axis_tready <= ($urandom_range(0, 3) != 0);
                    3: m_axis_tready <= ($urandom_range(0, 4) == 0);
                    default: m_axis_tready <= 1'b0;
                endcase
            end
        end
    end

    // Watchdog: end the run if it hangs.
    initial begin
        for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++)
            @(posedge aclk);
        $display("status: fail");
        $finish;
    end

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed extremes and corner cases, then let them drain
        foreach (DIRECTED_BYTES[i])
            plan_byte(DIRECTED_BYTES[i][7:0], DIRECTED_BYTES[i][8]);
        send_plan();
        wait_for_drain();

        // random text in two halves with a full drain between them
        plan_random_text(800);
        send_plan();
        wait_for_drain();
        plan_random_text(850);
        send_plan();
        wait_for_drain();
        repeat (SETTLE) @(posedge aclk);

        $display("covered %0d bytes: directed extremes, well-formed and broken sequences,",
                 bytes_sent);
        $display("bad leads, lone continuations and stream starts; %0d words checked",
                 words_checked);
        if (fail_count == 0 && words_pending == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
